// File: src/epdm_pkg.sv
// Shared widths, register indexes and conversion constants for the echo distance meter.
package epdm_pkg;

	// Field and datapath widths.
	localparam int unsigned TIME_W      = 16;
	localparam int unsigned WIDTH_W     = 16;
	localparam int unsigned CFG_W       = 18;
	localparam int unsigned THR_W       = 18;
	localparam int unsigned RAW_W       = 19;
	localparam int unsigned SAMPLE_W    = 21;
	localparam int unsigned CM_W        = 21;
	localparam int unsigned INCH_W      = 20;
	localparam int unsigned CAL_SUM_W   = 28;
	localparam int unsigned RAW_NUM_W   = 27;
	localparam int unsigned INCH_NUM_W  = 26;

	// Configuration register indexes.
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_ALARM_THRESHOLD  = 2'd0;
	localparam reg_idx_t REG_REF_DISTANCE     = 2'd1;
	localparam reg_idx_t REG_CALIBRATE_ENABLE = 2'd2;

	// Raw distance: (width * 4352 + 500) / 1000 reduces to (width * 1088 + 125) / 250.
	localparam logic [RAW_NUM_W-1:0] RAW_SCALE = 27'd1088;
	localparam logic [RAW_NUM_W-1:0] RAW_BIAS  = 27'd125;
	localparam int unsigned          RAW_DIV   = 250;

	// Inches: (|cm| * 100 + 127) / 254 reduces to (|cm| * 50 + 63) / 127.
	localparam logic [INCH_NUM_W-1:0] INCH_SCALE = 26'd50;
	localparam logic [INCH_NUM_W-1:0] INCH_BIAS  = 26'd63;
	localparam int unsigned           INCH_DIV   = 127;

	// Saturation limits of the signed Q8 centimetre value.
	localparam logic [CM_W-1:0] CM_MAX = 21'h0FFFFF;
	localparam logic [CM_W-1:0] CM_MIN = 21'h100000;

endpackage

// File: src/epdm_cdiv.sv
// Two-stage unsigned divider by a constant: reciprocal multiply, then one correction step.
module epdm_cdiv #(
	parameter int unsigned DIVISOR = 250,
	parameter int unsigned NUM_W   = 27
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	output logic [NUM_W-1:0] quo
);

	localparam int unsigned      PROD_W = 2 * NUM_W + 1;
	localparam logic [NUM_W:0]   RCP    = (NUM_W + 1)'((64'd1 << NUM_W) / 64'(DIVISOR));
	localparam logic [NUM_W-1:0] DIV_K  = NUM_W'(DIVISOR);

	logic [PROD_W-1:0] prod_s1;
	logic [NUM_W-1:0]  num_s1;
	logic [NUM_W-1:0]  quo_s2;
	logic [NUM_W-1:0]  est;
	logic [NUM_W-1:0]  rem;

	// The estimate is the true quotient or one below it, so one compare fixes it.
	assign est = prod_s1[2*NUM_W-1:NUM_W];
	assign rem = num_s1 - est * DIV_K;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(num) * PROD_W'(RCP);
			num_s1  <= num;
			quo_s2  <= est + NUM_W'(rem >= DIV_K);
		end
	end

	assign quo = quo_s2;

endmodule

// File: src/echo_pulse_distance_meter_unit.sv
// Echo pulse distance meter: top level with the measurement and calibration pipeline.
//
// Each transfer on the input channel carries one echo edge timestamp; edges alternate
// rising, falling, starting with a rising edge after reset. The block takes one edge
// every clock cycle while the output register is not stalled. A rising edge only
// records its time; a falling edge yields one result (pulse width, distance in Q8 cm
// and Q8 inches, near alarm, calibration status) on the output channel, and results
// are kept in edge order. The pipeline holds three constant dividers (reciprocal
// multiply plus correction, two stages each) in a row: width to centimetres, the
// calibration average, and centimetres to inches. While the output register holds
// a result that is stalled, the whole pipeline holds and the input channel stalls
// with it. The configuration port always accepts writes and must be written only
// while no falling edge is in flight. Calibration starts when 1 is written to
// calibrate_enable: the next CAL_SAMPLES echo pulses are averaged as
// (ref_distance - raw distance), and the edge that completes the average already
// uses the new offset.
module echo_pulse_distance_meter_unit #(
	parameter int unsigned CAL_SAMPLES = 100,
	parameter int unsigned TIMER_BITS  = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// Echo edge channel.
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic [epdm_pkg::TIME_W-1:0]             echo_time,
	// Result channel.
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic [epdm_pkg::WIDTH_W-1:0]            pulse_width,
	output logic signed [epdm_pkg::CM_W-1:0]        distance_cm,
	output logic signed [epdm_pkg::INCH_W-1:0]      distance_inch,
	output logic                                    near_alarm,
	output logic                                    calibration_done,
	// Configuration write channel.
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  epdm_pkg::reg_idx_t                      cfg_index,
	input  logic [epdm_pkg::CFG_W-1:0]              cfg_data
);

	localparam int unsigned TW = ((TIMER_BITS > epdm_pkg::TIME_W) ?
		TIMER_BITS : epdm_pkg::TIME_W) + 1;
	localparam logic [TW-1:0] TMAX = TW'((64'd1 << TIMER_BITS) - 64'd1);
	localparam logic [epdm_pkg::TIME_W-1:0] TMASK = TMAX[epdm_pkg::TIME_W-1:0];
	localparam int unsigned CNT_W = $clog2(CAL_SAMPLES + 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAL_SAMPLES);
	localparam logic [epdm_pkg::CAL_SUM_W-1:0] CAL_HALF =
		epdm_pkg::CAL_SUM_W'(CAL_SAMPLES / 2);
	localparam logic [epdm_pkg::CAL_SUM_W-1:0] POS_LIM =
		epdm_pkg::CAL_SUM_W'(epdm_pkg::CM_MAX);
	localparam logic [epdm_pkg::CAL_SUM_W-1:0] NEG_LIM = POS_LIM + 1'b1;

	// Sideband carried alongside the calibration divider.
	typedef struct packed {
		logic [epdm_pkg::WIDTH_W-1:0] width;
		logic [epdm_pkg::RAW_W-1:0]   raw;
		logic                         fin;
		logic                         done;
		logic                         neg;
	} cal_side_t;

	// Sideband carried alongside the inch divider.
	typedef struct packed {
		logic [epdm_pkg::WIDTH_W-1:0] width;
		logic [epdm_pkg::CM_W-1:0]    cm;
		logic                         near;
		logic                         done;
		logic                         neg;
	} res_side_t;

	logic                               adv;
	logic                               cfg_wr;
	logic [14:1]                        vld_s;

	// Configuration registers.
	logic [epdm_pkg::THR_W-1:0]         thr_q;
	logic [epdm_pkg::THR_W-1:0]         ref_q;
	logic                               cal_en_q;

	// Edge tracking state.
	logic                               awaiting_q;
	logic [epdm_pkg::TIME_W-1:0]        rise_q;
	logic [epdm_pkg::WIDTH_W-1:0]       last_width_q;

	// Calibration state.
	logic signed [epdm_pkg::CAL_SUM_W-1:0] cal_sum_q;
	logic [CNT_W-1:0]                   cal_count_q;
	logic                               cal_done_q;
	logic [epdm_pkg::CM_W-1:0]          offset_q;

	// Pipeline registers.
	logic [epdm_pkg::TIME_W-1:0]        t_s1;
	logic [epdm_pkg::WIDTH_W-1:0]       w_s2, w_s3, w_s4, w_s5;
	logic [epdm_pkg::RAW_NUM_W-1:0]     m_s3;
	cal_side_t                          side_s6, side_s7, side_s8, side_s9, side_s10;
	logic [epdm_pkg::CAL_SUM_W-1:0]     sum_s6;
	logic [epdm_pkg::CAL_SUM_W-1:0]     n_s7;
	res_side_t                          side_s11, side_s12, side_s13, side_s14;
	logic [epdm_pkg::INCH_NUM_W-1:0]    x_s12;

	// Output register.
	logic                               out_valid_q;
	logic [epdm_pkg::WIDTH_W-1:0]       pulse_width_q;
	logic [epdm_pkg::CM_W-1:0]          cm_q;
	logic [epdm_pkg::INCH_W-1:0]        inch_q;
	logic                               near_q;
	logic                               done_q;

	// Combinational stage logic.
	logic [epdm_pkg::TIME_W-1:0]        t_c;
	logic [TW-1:0]                      wrap_c;
	logic [epdm_pkg::WIDTH_W-1:0]       width_c;
	logic [epdm_pkg::RAW_NUM_W-1:0]     raw_quo;
	logic [epdm_pkg::RAW_W-1:0]         raw_s5;
	logic [epdm_pkg::SAMPLE_W-1:0]      sample_c;
	logic [epdm_pkg::CAL_SUM_W-1:0]     sum_next;
	logic [CNT_W-1:0]                   cnt_next;
	logic                               cal_active;
	logic                               cal_hit;
	logic [epdm_pkg::CAL_SUM_W-1:0]     sum_mag_c;
	logic [epdm_pkg::CAL_SUM_W-1:0]     cal_quo;
	logic [epdm_pkg::CM_W-1:0]          off_c;
	logic [epdm_pkg::CM_W:0]            cm_sum_c;
	logic [epdm_pkg::CM_W-1:0]          cm_c;
	logic [epdm_pkg::CM_W-1:0]          cm_mag_c;
	logic [epdm_pkg::INCH_NUM_W-1:0]    x_c;
	logic                               near_c;
	logic [epdm_pkg::INCH_NUM_W-1:0]    inch_quo;
	logic [epdm_pkg::INCH_W-1:0]        inch_mag_c;
	logic [epdm_pkg::INCH_W-1:0]        inch_c;

	// The pipeline moves whenever the output register is empty or being taken.
	assign adv       = !out_valid_q || !out_stall;
	assign in_stall  = !adv;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= '0;
			ref_q    <= '0;
			cal_en_q <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_index)
				epdm_pkg::REG_ALARM_THRESHOLD:  thr_q    <= cfg_data;
				epdm_pkg::REG_REF_DISTANCE:     ref_q    <= cfg_data;
				epdm_pkg::REG_CALIBRATE_ENABLE: cal_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Valid bits: rising edges leave the pipeline after the first stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[13:2], vld_s[1] && awaiting_q, in_valid};
		end
	end

	// Pulse width with timer wrap handling; an equal timestamp reuses the last width.
	always_comb begin
		t_c    = t_s1 & TMASK;
		wrap_c = TMAX - TW'(rise_q) + TW'(t_c);
		if (t_c > rise_q) begin
			width_c = t_c - rise_q;
		end else if (rise_q > t_c) begin
			width_c = (|wrap_c[TW-1:epdm_pkg::WIDTH_W]) ? '1 : wrap_c[epdm_pkg::WIDTH_W-1:0];
		end else begin
			width_c = last_width_q;
		end
	end

	// Edge tracking state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q   <= 1'b0;
			rise_q       <= '0;
			last_width_q <= '0;
		end else if (adv && vld_s[1]) begin
			awaiting_q <= !awaiting_q;
			if (awaiting_q) begin
				last_width_q <= width_c;
			end else begin
				rise_q <= t_c;
			end
		end
	end

	// Width to raw centimetres: numerator then constant divide.
	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1 <= echo_time;
			w_s2 <= width_c;
			w_s3 <= w_s2;
			m_s3 <= epdm_pkg::RAW_NUM_W'(w_s2) * epdm_pkg::RAW_SCALE + epdm_pkg::RAW_BIAS;
			w_s4 <= w_s3;
			w_s5 <= w_s4;
		end
	end

	epdm_cdiv #(
		.DIVISOR(epdm_pkg::RAW_DIV),
		.NUM_W  (epdm_pkg::RAW_NUM_W)
	) u_raw_div (
		.clk(clk),
		.en (adv),
		.num(m_s3),
		.quo(raw_quo)
	);

	assign raw_s5 = raw_quo[epdm_pkg::RAW_W-1:0];

	// Calibration sample: reference minus raw distance, accumulated over the window.
	assign sample_c   = {3'b000, ref_q} - {2'b00, raw_s5};
	assign sum_next   = cal_sum_q + {{(epdm_pkg::CAL_SUM_W - epdm_pkg::SAMPLE_W)
		{sample_c[epdm_pkg::SAMPLE_W-1]}}, sample_c};
	assign cnt_next   = cal_count_q + 1'b1;
	assign cal_active = cal_en_q && !cal_done_q;
	assign cal_hit    = cal_active && (cnt_next == CNT_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_sum_q   <= '0;
			cal_count_q <= '0;
			cal_done_q  <= 1'b0;
		end else if (cfg_wr && cfg_index == epdm_pkg::REG_CALIBRATE_ENABLE) begin
			cal_sum_q   <= '0;
			cal_count_q <= '0;
			if (cfg_data[0]) begin
				cal_done_q <= 1'b0;
			end
		end else if (adv && vld_s[5] && cal_active) begin
			if (cal_hit) begin
				cal_sum_q   <= '0;
				cal_count_q <= '0;
				cal_done_q  <= 1'b1;
			end else begin
				cal_sum_q   <= sum_next;
				cal_count_q <= cnt_next;
			end
		end
	end

	// Magnitude of the finished sum, biased for round-half-away-from-zero.
	assign sum_mag_c = (sum_s6[epdm_pkg::CAL_SUM_W-1] ? -sum_s6 : sum_s6) + CAL_HALF;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s6.width <= w_s5;
			side_s6.raw   <= raw_s5;
			side_s6.fin   <= cal_hit;
			side_s6.done  <= cal_done_q || cal_hit;
			side_s6.neg   <= sum_next[epdm_pkg::CAL_SUM_W-1];
			sum_s6        <= sum_next;
			side_s7       <= side_s6;
			n_s7          <= sum_mag_c;
			side_s8       <= side_s7;
			side_s9       <= side_s8;
		end
	end

	epdm_cdiv #(
		.DIVISOR(CAL_SAMPLES),
		.NUM_W  (epdm_pkg::CAL_SUM_W)
	) u_cal_div (
		.clk(clk),
		.en (adv),
		.num(n_s7),
		.quo(cal_quo)
	);

	// Signed, saturated average becomes the new offset.
	always_comb begin
		if (!side_s9.neg && cal_quo > POS_LIM) begin
			off_c = epdm_pkg::CM_MAX;
		end else if (side_s9.neg && cal_quo > NEG_LIM) begin
			off_c = epdm_pkg::CM_MIN;
		end else if (side_s9.neg) begin
			off_c = -cal_quo[epdm_pkg::CM_W-1:0];
		end else begin
			off_c = cal_quo[epdm_pkg::CM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (adv && vld_s[9] && side_s9.fin) begin
			offset_q <= off_c;
		end
	end

	// Corrected distance, saturated to the signed output range.
	always_comb begin
		cm_sum_c = {3'b000, side_s10.raw} + {offset_q[epdm_pkg::CM_W-1], offset_q};
		if (cm_sum_c[epdm_pkg::CM_W] != cm_sum_c[epdm_pkg::CM_W-1]) begin
			cm_c = cm_sum_c[epdm_pkg::CM_W] ? epdm_pkg::CM_MIN : epdm_pkg::CM_MAX;
		end else begin
			cm_c = cm_sum_c[epdm_pkg::CM_W-1:0];
		end
	end

	// Near alarm from the corrected distance.
	assign near_c   = $signed({cm_c[epdm_pkg::CM_W-1], cm_c}) <
		$signed({4'b0000, thr_q});

	// Inch numerator from the corrected distance.
	assign cm_mag_c = side_s11.cm[epdm_pkg::CM_W-1] ? -side_s11.cm : side_s11.cm;
	assign x_c      = epdm_pkg::INCH_NUM_W'(cm_mag_c) * epdm_pkg::INCH_SCALE +
		epdm_pkg::INCH_BIAS;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s10       <= side_s9;
			side_s11.width <= side_s10.width;
			side_s11.cm    <= cm_c;
			side_s11.near  <= near_c;
			side_s11.done  <= side_s10.done;
			side_s11.neg   <= cm_c[epdm_pkg::CM_W-1];
			side_s12       <= side_s11;
			x_s12          <= x_c;
			side_s13       <= side_s12;
			side_s14       <= side_s13;
		end
	end

	epdm_cdiv #(
		.DIVISOR(epdm_pkg::INCH_DIV),
		.NUM_W  (epdm_pkg::INCH_NUM_W)
	) u_inch_div (
		.clk(clk),
		.en (adv),
		.num(x_s12),
		.quo(inch_quo)
	);

	// Restore the sign of the inch value; its magnitude never exceeds 19 bits.
	assign inch_mag_c = {1'b0, inch_quo[epdm_pkg::INCH_W-2:0]};
	assign inch_c     = side_s14.neg ? -inch_mag_c : inch_mag_c;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s[14];
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s[14]) begin
			pulse_width_q <= side_s14.width;
			cm_q          <= side_s14.cm;
			inch_q        <= inch_c;
			near_q        <= side_s14.near;
			done_q        <= side_s14.done;
		end
	end

	assign out_valid        = out_valid_q;
	assign pulse_width      = pulse_width_q;
	assign distance_cm      = cm_q;
	assign distance_inch    = inch_q;
	assign near_alarm       = near_q;
	assign calibration_done = done_q;

	// The sample count never reaches the window length; it wraps to zero there.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cal_count_q < CNT_LAST)
		else $error("calibration count reached the window length");

	// An empty window always holds an empty sum.
	a_sum_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(cal_count_q == '0) |-> (cal_sum_q == '0))
		else $error("calibration sum not cleared with the count");

	// Calibration completes only on a falling edge that closes the window.
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cal_done_q) |-> $past(adv && vld_s[5] && cal_hit))
		else $error("calibration done set without a completed window");

	// The offset changes only when a finished average reaches the offset stage.
	a_offset_source: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(offset_q) |-> $past(adv && vld_s[9] && side_s9.fin))
		else $error("offset changed without a finished calibration");

endmodule

// File: test/testbench.sv
// Self-checking testbench for the echo pulse distance meter unit.
`timescale 1ns / 100ps

module testbench;

	// Index that is not mapped to any register.
	localparam epdm_pkg::reg_idx_t REG_UNUSED = 2'd3;
	localparam int CAL_SAMPLES = 100;
	localparam longint TIMER_TOP = 65535;
	// Cycles to let rising edges leave the pipeline once no result is outstanding.
	localparam int PIPE_SETTLE = 24;

	typedef struct {
		logic [epdm_pkg::WIDTH_W-1:0]       width;
		logic signed [epdm_pkg::CM_W-1:0]   cm;
		logic signed [epdm_pkg::INCH_W-1:0] inch;
		logic                               alarm;
		logic                               cal_done;
	} echo_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [epdm_pkg::TIME_W-1:0] echo_time = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [epdm_pkg::WIDTH_W-1:0] pulse_width;
	logic signed [epdm_pkg::CM_W-1:0] distance_cm;
	logic signed [epdm_pkg::INCH_W-1:0] distance_inch;
	logic near_alarm;
	logic calibration_done;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	epdm_pkg::reg_idx_t cfg_index = epdm_pkg::REG_ALARM_THRESHOLD;
	logic [epdm_pkg::CFG_W-1:0] cfg_data = '0;

	// Idling controls and the long receiver hold-off counter.
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int stall_hold = 0;
	int mismatch_count = 0;

	echo_result_t expected_echoes[$];

	// Predicted register contents.
	logic [epdm_pkg::THR_W-1:0] thr_reg = '0;
	logic [epdm_pkg::CFG_W-1:0] ref_reg = '0;
	logic                       cal_en_reg = 1'b0;

	// Predicted measurement and calibration state.
	logic                                  expect_fall = 1'b0;
	logic [epdm_pkg::TIME_W-1:0]           rise_stamp = '0;
	logic [epdm_pkg::WIDTH_W-1:0]          prev_width = '0;
	logic signed [epdm_pkg::CM_W-1:0]      cal_offset = '0;
	logic signed [epdm_pkg::CAL_SUM_W-1:0] cal_acc = '0;
	logic [6:0]                            cal_pulses = '0;
	logic                                  cal_finished = 1'b0;

	echo_pulse_distance_meter_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.echo_time        (echo_time),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.pulse_width      (pulse_width),
		.distance_cm      (distance_cm),
		.distance_inch    (distance_inch),
		.near_alarm       (near_alarm),
		.calibration_done (calibration_done),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Run limit, far above the slowest legal run.
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Division rounded to nearest, ties away from zero; den is positive.
	function automatic longint round_div(input longint num, input longint den);
		if (num >= 0) return (num + den / 2) / den;
		return -((-num + den / 2) / den);
	endfunction

	// Mirror a register write in the predicted state.
	function automatic void apply_write(input epdm_pkg::reg_idx_t idx,
		input logic [epdm_pkg::CFG_W-1:0] data);
		case (idx)
			epdm_pkg::REG_ALARM_THRESHOLD: begin
				thr_reg = data;
			end
			epdm_pkg::REG_REF_DISTANCE: begin
				ref_reg = data;
			end
			epdm_pkg::REG_CALIBRATE_ENABLE: begin
				cal_en_reg = data[0];
				cal_acc = '0;
				cal_pulses = '0;
				if (data[0]) cal_finished = 1'b0;
			end
			default: begin
			end
		endcase
	endfunction

	// Advance the predicted state by one echo edge; a falling edge queues its result.
	function automatic void measure_edge(input logic [epdm_pkg::TIME_W-1:0] stamp);
		longint w, raw, acc, q, cm, inch;
		echo_result_t r;
		if (!expect_fall) begin
			rise_stamp = stamp;
			expect_fall = 1'b1;
			return;
		end
		expect_fall = 1'b0;

		// Pulse width with timer wrap; an equal stamp repeats the previous width.
		if (stamp > rise_stamp) w = stamp - rise_stamp;
		else if (rise_stamp > stamp) w = (TIMER_TOP - rise_stamp) + stamp;
		else w = prev_width;
		if (w > 65535) w = 65535;
		prev_width = w[epdm_pkg::WIDTH_W-1:0];

		raw = (w * 4352 + 500) / 1000;

		// Calibration sample; the completing edge already sees the new offset.
		if (cal_en_reg && !cal_finished) begin
			acc = longint'(cal_acc) + longint'(ref_reg) - raw;
			cal_acc = acc[epdm_pkg::CAL_SUM_W-1:0];
			cal_pulses = cal_pulses + 7'd1;
			if (cal_pulses >= CAL_SAMPLES) begin
				q = clamp(round_div(acc, CAL_SAMPLES), -1048576, 1048575);
				cal_offset = q[epdm_pkg::CM_W-1:0];
				cal_finished = 1'b1;
				cal_acc = '0;
				cal_pulses = '0;
			end
		end

		cm = clamp(raw + longint'(cal_offset), -1048576, 1048575);
		inch = clamp(round_div(cm * 100, 254), -524288, 524287);
		r.width = w[epdm_pkg::WIDTH_W-1:0];
		r.cm = cm[epdm_pkg::CM_W-1:0];
		r.inch = inch[epdm_pkg::INCH_W-1:0];
		r.alarm = (cm < longint'(thr_reg));
		r.cal_done = cal_finished;
		expected_echoes.push_back(r);
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 50) $display("%0t: mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(negedge clk) begin
		if (stall_hold > 0) begin
			out_stall <= 1'b1;
			stall_hold = stall_hold - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Compare every result transfer with the oldest prediction.
	always @(posedge clk) begin : result_check
		echo_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_echoes.size() == 0) begin
				report_mismatch($sformatf("result with none outstanding, pulse_width %0d",
					pulse_width));
			end else begin
				want = expected_echoes.pop_front();
				if (pulse_width !== want.width)
					report_mismatch($sformatf("pulse_width %0d, expected %0d",
						pulse_width, want.width));
				if (distance_cm !== want.cm)
					report_mismatch($sformatf("distance_cm %0d, expected %0d",
						distance_cm, want.cm));
				if (distance_inch !== want.inch)
					report_mismatch($sformatf("distance_inch %0d, expected %0d",
						distance_inch, want.inch));
				if (near_alarm !== want.alarm)
					report_mismatch($sformatf("near_alarm %b, expected %b",
						near_alarm, want.alarm));
				if (calibration_done !== want.cal_done)
					report_mismatch($sformatf("calibration_done %b, expected %b",
						calibration_done, want.cal_done));
			end
		end
	end

	// Withdraw any offered edge, change the idling rates away from the falling edge,
	// then return to it.
	task automatic set_idling(input int gap_pct, input int stall_pct);
		in_valid <= 1'b0;
		@(posedge clk);
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		@(negedge clk);
	endtask

	// Offer one edge timestamp and hold it until the transfer completes.
	task automatic send_edge(input logic [epdm_pkg::TIME_W-1:0] stamp);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			echo_time <= epdm_pkg::TIME_W'($urandom);
			@(negedge clk);
		end
		in_valid <= 1'b1;
		echo_time <= stamp;
		do @(posedge clk); while (in_stall !== 1'b0);
		measure_edge(stamp);
		@(negedge clk);
	endtask

	task automatic send_pulse(input logic [epdm_pkg::TIME_W-1:0] rise,
		input logic [epdm_pkg::TIME_W-1:0] fall);
		send_edge(rise);
		send_edge(fall);
	endtask

	// Random pulse: mostly realistic widths, plus wraps, equal stamps and noise.
	task automatic random_pulse();
		logic [epdm_pkg::TIME_W-1:0] rise, fall;
		int pick;
		pick = $urandom_range(99);
		rise = epdm_pkg::TIME_W'($urandom);
		if (pick < 55) begin
			fall = rise + epdm_pkg::TIME_W'($urandom_range(4000));
		end else if (pick < 75) begin
			fall = rise + epdm_pkg::TIME_W'($urandom_range(30000));
		end else if (pick < 85) begin
			fall = epdm_pkg::TIME_W'($urandom);
		end else if (pick < 92) begin
			fall = rise;
		end else begin
			rise = epdm_pkg::TIME_W'($urandom_range(65535, 60000));
			fall = epdm_pkg::TIME_W'($urandom_range(3000));
		end
		send_pulse(rise, fall);
	endtask

	// Stop offering edges and wait until every result has arrived and the pipe is empty.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_echoes.size() != 0) @(negedge clk);
		repeat (PIPE_SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input epdm_pkg::reg_idx_t idx,
		input logic [epdm_pkg::CFG_W-1:0] data);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		apply_write(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Register value biased toward the extremes.
	function automatic logic [epdm_pkg::CFG_W-1:0] pick_level();
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			2: return epdm_pkg::CFG_W'($urandom_range(20000));
			default: return epdm_pkg::CFG_W'($urandom);
		endcase
	endfunction

	// Enable word with random upper bits, which the register must drop.
	function automatic logic [epdm_pkg::CFG_W-1:0] enable_word(input logic on);
		return {17'($urandom), on};
	endfunction

	// Width extremes, timer wrap and equal timestamps.
	task automatic test_edge_timing();
		send_pulse(16'd0, 16'd0);
		send_pulse(16'd100, 16'd1100);
		send_pulse(16'd5000, 16'd5000);
		send_pulse(16'd65000, 16'd100);
		send_pulse(16'd65535, 16'd0);
		send_pulse(16'd1, 16'd0);
		send_pulse(16'd0, 16'd65535);
		send_pulse(16'd65534, 16'd65535);
		send_pulse(16'd65535, 16'd65535);
	endtask

	// Near alarm around both threshold extremes, and a write to an unmapped index.
	task automatic test_alarm_limits();
		write_reg(epdm_pkg::REG_ALARM_THRESHOLD, '1);
		send_pulse(16'd0, 16'd60234);
		send_pulse(16'd100, 16'd60335);
		send_pulse(16'd2, 16'd60238);
		write_reg(REG_UNUSED, '1);
		write_reg(epdm_pkg::REG_ALARM_THRESHOLD, '0);
		send_pulse(16'd10, 16'd10);
	endtask

	// Random pulses with the alarm threshold changed every so often.
	task automatic test_random_traffic(input int pulses);
		for (int i = 0; i < pulses; i++) begin
			if (i % 20 == 19) write_reg(epdm_pkg::REG_ALARM_THRESHOLD, pick_level());
			random_pulse();
		end
	endtask

	// One calibration run, sometimes restarted part way, then switched off.
	task automatic test_calibration();
		int cut;
		write_reg(epdm_pkg::REG_REF_DISTANCE, pick_level());
		write_reg(epdm_pkg::REG_CALIBRATE_ENABLE, enable_word(1'b1));
		if ($urandom_range(1)) begin
			cut = $urandom_range(99, 1);
			repeat (cut) random_pulse();
			// Restart either directly or after switching calibration off.
			if ($urandom_range(1))
				write_reg(epdm_pkg::REG_CALIBRATE_ENABLE, enable_word(1'b0));
			write_reg(epdm_pkg::REG_CALIBRATE_ENABLE, enable_word(1'b1));
		end
		repeat (CAL_SAMPLES + $urandom_range(30, 5)) random_pulse();
		write_reg(epdm_pkg::REG_CALIBRATE_ENABLE, enable_word(1'b0));
		repeat (10) random_pulse();
	endtask

	// Long receiver hold-off so the pipeline fills, then a full drain before more edges.
	task automatic test_backpressure();
		set_idling(0, 0);
		@(posedge clk);
		stall_hold = 300;
		@(negedge clk);
		repeat (60) random_pulse();
		wait_idle();
		set_idling(12, 30);
		repeat (20) random_pulse();
	endtask

	initial begin
		int spins;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		set_idling(12, 77);
		test_edge_timing();
		test_alarm_limits();

		// Three idling patterns: slow receiver, slow sender, then no idling.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: set_idling(12, 77);
				1: set_idling(77, 12);
				default: set_idling(0, 0);
			endcase
			test_random_traffic(60);
			test_calibration();
			test_random_traffic(30);
		end

		test_backpressure();

		// Drain whatever is still outstanding, within a bound.
		in_valid <= 1'b0;
		for (spins = 0; spins < 5000 && expected_echoes.size() != 0; spins++)
			@(negedge clk);
		repeat (PIPE_SETTLE) @(negedge clk);
		if (expected_echoes.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_echoes.size()));

		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
